### src/ijic_pkg.sv
// Shared types, constants and register codes for the intake jam guard and item counter.
package ijic_pkg;

   // Magazine capacity and the width of the item counter
   localparam int MaxDiscs   = 15;
   localparam int CountWidth = $clog2(MaxDiscs + 1);

   // Motor drive levels in millivolts; HoldEmpty is a roller hold length in ticks
   localparam logic signed [14:0] DriveFwd  = 15'sd12000;
   localparam logic signed [14:0] DriveRev  = -15'sd12000;
   localparam logic signed [14:0] DriveOut  = -15'sd10000;
   localparam logic [12:0]        RollerOn  = 13'd8000;
   localparam logic [5:0]         HoldEmpty = 6'd20;

   // Register reset values
   localparam logic [9:0]  StallVelocityRst    = 10'd100;
   localparam logic [11:0] StallCurrentRst     = 12'd150;
   localparam logic [7:0]  JamTickLimitRst     = 8'd10;
   localparam logic [15:0] ReverseTimeMsRst    = 16'd1000;
   localparam logic [13:0] NearDistanceRst     = 14'd15;
   localparam logic [13:0] DistanceJumpRst     = 14'd50;
   localparam logic [5:0]  HoldAutoLoadedRst   = 6'd28;
   localparam logic [5:0]  HoldManualLoadedRst = 6'd25;

   typedef enum logic [1:0] {
      MODE_AUTO    = 2'd0,
      MODE_MANUAL  = 2'd1,
      MODE_OUTTAKE = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_STALL_VELOCITY     = 3'd0,
      CSR_STALL_CURRENT      = 3'd1,
      CSR_JAM_TICK_LIMIT     = 3'd2,
      CSR_REVERSE_TIME_MS    = 3'd3,
      CSR_NEAR_DISTANCE      = 3'd4,
      CSR_DISTANCE_JUMP      = 3'd5,
      CSR_HOLD_AUTO_LOADED   = 3'd6,
      CSR_HOLD_MANUAL_LOADED = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  stall_velocity;
      logic [11:0] stall_current;
      logic [7:0]  jam_tick_limit;
      logic [15:0] reverse_time_ms;
      logic [13:0] near_distance;
      logic [13:0] distance_jump;
      logic [5:0]  hold_auto_loaded;
      logic [5:0]  hold_manual_loaded;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [10:0] motor_velocity;
      logic [11:0]        motor_current;
      logic [13:0]        sensed_distance;
      logic [31:0]        time_ms;
   } item_type;

   typedef struct packed {
      logic signed [14:0] intake_drive;
      logic [12:0]        roller_drive;
      logic [3:0]         item_count;
      logic               reversing;
   } result_type;

endpackage

### src/ijic_csr.sv
// Configuration register file for the intake jam guard.
module ijic_csr
   import ijic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index and take the low bits of the write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_STALL_VELOCITY:     cfg_in.stall_velocity     = csr_data[9:0];
            CSR_STALL_CURRENT:      cfg_in.stall_current      = csr_data[11:0];
            CSR_JAM_TICK_LIMIT:     cfg_in.jam_tick_limit     = csr_data[7:0];
            CSR_REVERSE_TIME_MS:    cfg_in.reverse_time_ms    = csr_data;
            CSR_NEAR_DISTANCE:      cfg_in.near_distance      = csr_data[13:0];
            CSR_DISTANCE_JUMP:      cfg_in.distance_jump      = csr_data[13:0];
            CSR_HOLD_AUTO_LOADED:   cfg_in.hold_auto_loaded   = csr_data[5:0];
            CSR_HOLD_MANUAL_LOADED: cfg_in.hold_manual_loaded = csr_data[5:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stall_velocity     <= StallVelocityRst;
         cfg_ff.stall_current      <= StallCurrentRst;
         cfg_ff.jam_tick_limit     <= JamTickLimitRst;
         cfg_ff.reverse_time_ms    <= ReverseTimeMsRst;
         cfg_ff.near_distance      <= NearDistanceRst;
         cfg_ff.distance_jump      <= DistanceJumpRst;
         cfg_ff.hold_auto_loaded   <= HoldAutoLoadedRst;
         cfg_ff.hold_manual_loaded <= HoldManualLoadedRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/ijic_core.sv
// Tick state and next-state logic: jam guard, roller hold and item counter.
module ijic_core
   import ijic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       advance,
   output result_type result
);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [13:0]           prev_ff, prev_in;
   logic [5:0]            hold_ff, hold_in;
   logic [7:0]            stall_ff, stall_in;
   logic [31:0]           rstart_ff, rstart_in;
   logic signed [14:0]    intake_ff, intake_in;
   logic                  roller_ff, roller_in;

   logic [10:0] abs_vel;
   logic        stalled;
   logic        near;
   logic        jump_in;
   logic        jump_out;
   logic [32:0] window_end;
   logic [5:0]  hold_loaded;
   logic        rev;

   // Condition flags of the current tick
   always_comb begin
      abs_vel  = item.motor_velocity[10] ? 11'(-item.motor_velocity)
                                         : 11'(item.motor_velocity);
      stalled  = (abs_vel < {1'b0, cfg.stall_velocity}) &&
                 (item.motor_current > cfg.stall_current);
      near     = item.sensed_distance < cfg.near_distance;
      jump_in  = {1'b0, prev_ff} > ({1'b0, item.sensed_distance} + {1'b0, cfg.distance_jump});
      jump_out = {1'b0, item.sensed_distance} > ({1'b0, prev_ff} + {1'b0, cfg.distance_jump});
   end

   // Next state per mode
   always_comb begin
      count_in    = count_ff;
      prev_in     = prev_ff;
      hold_in     = hold_ff;
      stall_in    = stall_ff;
      rstart_in   = rstart_ff;
      intake_in   = intake_ff;
      roller_in   = roller_ff;
      rev         = 1'b0;
      window_end  = 33'd0;
      hold_loaded = (item.mode == MODE_AUTO) ? cfg.hold_auto_loaded : cfg.hold_manual_loaded;

      unique case (item.mode)
         MODE_AUTO, MODE_MANUAL: begin
            if (item.mode == MODE_AUTO) begin
               // Count stalled ticks, latch the reverse window past the limit
               if (stalled) begin
                  stall_in = (stall_ff != 8'hFF) ? stall_ff + 8'd1 : stall_ff;
               end else begin
                  stall_in = 8'd0;
               end
               if (stall_in > cfg.jam_tick_limit) begin
                  rstart_in = item.time_ms;
               end
               window_end = {1'b0, rstart_in} + {17'd0, cfg.reverse_time_ms};
               if ({1'b0, item.time_ms} > window_end) begin
                  intake_in = DriveFwd;
               end else begin
                  intake_in = DriveRev;
                  rev       = 1'b1;
               end
            end else begin
               intake_in = DriveFwd;
            end
            // Roller hold and count in
            if (near) begin
               hold_in   = (count_ff != '0) ? hold_loaded : HoldEmpty;
               roller_in = 1'b1;
               if (jump_in) begin
                  count_in = (count_ff < CountWidth'(MaxDiscs)) ? count_ff + 1'b1
                                                                : CountWidth'(MaxDiscs);
               end
            end else if (hold_ff != '0) begin
               hold_in   = hold_ff - 6'd1;
               roller_in = 1'b1;
            end else begin
               roller_in = 1'b0;
            end
            prev_in = item.sensed_distance;
         end
         MODE_OUTTAKE: begin
            intake_in = DriveOut;
            if (jump_out && (count_ff != '0)) begin
               count_in = count_ff - 1'b1;
            end
            prev_in = item.sensed_distance;
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase

      result.intake_drive = intake_in;
      result.roller_drive = roller_in ? RollerOn : 13'd0;
      result.item_count   = 4'(count_in);
      result.reversing    = rev;
   end

   // Commit state as the tick leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         prev_ff   <= '0;
         hold_ff   <= '0;
         stall_ff  <= '0;
         rstart_ff <= '0;
         intake_ff <= '0;
         roller_ff <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         prev_ff   <= prev_in;
         hold_ff   <= hold_in;
         stall_ff  <= stall_in;
         rstart_ff <= rstart_in;
         intake_ff <= intake_in;
         roller_ff <= roller_in;
      end
   end

endmodule

### src/intake_jam_and_item_counter.sv
// Top level of the intake jam guard and magazine item counter.
//
//   channel  direction  beat contents
//   req_*    in         tuser: mode; tdata: motor_velocity, motor_current,
//                       sensed_distance, time_ms
//   rsp_*    out        tdata: intake_drive, roller_drive, item_count, reversing
//   csr_*    in         csr_index, csr_data (register write)
//
// One tick per cycle sustained while rsp_tready stays high; a result passes through
// the input register and then the result register.
// Synchronous active-high reset clears the tick state and restores the registers.
// A stall on rsp_tready holds the result register; the input register still
// takes one more beat, so the request side stops only when both are full.
module intake_jam_and_item_counter
   import ijic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [71:0] req_tdata,   // [10:0] motor_velocity, [22:11] motor_current,
                                    // [36:23] sensed_distance, [68:37] time_ms, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [14:0] intake_drive, [27:15] roller_drive,
                                    // [31:28] item_count, [32] reversing, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_open;
   logic       advance;

   ijic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ijic_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .advance (advance),
      .result  (result)
   );

   // Unpack the request beat
   always_comb begin
      req_item.mode            = mode_type'(req_tuser);
      req_item.motor_velocity  = req_tdata[10:0];
      req_item.motor_current   = req_tdata[22:11];
      req_item.sensed_distance = req_tdata[36:23];
      req_item.time_ms         = req_tdata[68:37];
   end

   // Pipeline handshake
   assign out_open     = !out_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_open;
   assign req_tready   = !in_valid_ff || out_open;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // Pack the result beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.reversing, out_ff.item_count,
                        out_ff.roller_drive, out_ff.intake_drive};

endmodule

### src/ijic_checker.sv
// Port-level checks for the intake jam guard, bound to the top level.
module ijic_checker
   import ijic_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // No result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed under stall");

   // Reversing always comes with the reverse drive
   a_rev_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> $signed(rsp_tdata[14:0]) == DriveRev)
      else $error("reversing without reverse drive");

   // Roller is either off or on at full level
   a_roller: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:15] == RollerOn || rsp_tdata[27:15] == 13'd0)
      else $error("roller drive out of set");

   // Count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[31:28]) <= 32'(MaxDiscs))
      else $error("item count above capacity");

endmodule

bind intake_jam_and_item_counter ijic_checker u_ijic_checker (.*);

### sim/ijic_drive_checker.sv
// Scoreboard for the intake jam guard: predicts every tick's drive result and compares it.
`timescale 1ns / 1ps

module ijic_drive_checker
   import ijic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [71:0] req_tdata,   // [10:0] motor_velocity, [22:11] motor_current,
                                    // [36:23] sensed_distance, [68:37] time_ms
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [14:0] intake_drive, [27:15] roller_drive,
                                    // [31:28] item_count, [32] reversing
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          outstanding,
   output int          mismatches
);

   // Register copy as seen on the write channel
   cfg_type cfg;

   // Predicted tick state
   int                 tally;
   logic [13:0]        last_distance;
   logic [5:0]         hold_left;
   int                 stall_run;
   logic [31:0]        reverse_start;
   logic signed [14:0] intake_drive;
   logic [12:0]        roller_drive;

   result_type drive_results [$];
   result_type want, got;
   item_type   tick_in;
   int         errors = 0;

   // Roller hold and count-in shared by both intake modes
   function automatic void roller_count_in(logic [13:0] reading, logic [5:0] hold_loaded);
      if (reading < cfg.near_distance) begin
         hold_left    = (tally > 0) ? hold_loaded : HoldEmpty;
         roller_drive = RollerOn;
         if (int'(last_distance) - int'(reading) > int'(cfg.distance_jump)) begin
            if (tally < MaxDiscs) tally++;
         end
      end else if (hold_left > 0) begin
         hold_left--;
         roller_drive = RollerOn;
      end else begin
         roller_drive = '0;
      end
      last_distance = reading;
   endfunction

   // Advance the predicted state by one tick and return its result
   function automatic result_type intake_tick(item_type t);
      int         vel;
      logic [32:0] window_end;
      logic       rev;
      result_type r;
      vel = int'(t.motor_velocity);
      if (vel < 0) vel = -vel;
      rev = 1'b0;
      case (t.mode)
         MODE_AUTO: begin
            if (vel < int'(cfg.stall_velocity) && t.motor_current > cfg.stall_current) begin
               if (stall_run < 255) stall_run++;
            end else begin
               stall_run = 0;
            end
            if (stall_run > int'(cfg.jam_tick_limit)) reverse_start = t.time_ms;
            // window end is formed without wrap
            window_end = {1'b0, reverse_start} + {17'b0, cfg.reverse_time_ms};
            if ({1'b0, t.time_ms} > window_end) begin
               intake_drive = DriveFwd;
            end else begin
               intake_drive = DriveRev;
               rev          = 1'b1;
            end
            roller_count_in(t.sensed_distance, cfg.hold_auto_loaded);
         end
         MODE_MANUAL: begin
            intake_drive = DriveFwd;
            roller_count_in(t.sensed_distance, cfg.hold_manual_loaded);
         end
         MODE_OUTTAKE: begin
            intake_drive = DriveOut;
            if (int'(t.sensed_distance) - int'(last_distance) > int'(cfg.distance_jump)) begin
               if (tally > 0) tally--;
            end
            last_distance = t.sensed_distance;
         end
         default: begin
            tally = 0;
         end
      endcase
      r.intake_drive = intake_drive;
      r.roller_drive = roller_drive;
      r.item_count   = tally[3:0];
      r.reversing    = rev;
      return r;
   endfunction

   function automatic void check_field(string name, logic signed [15:0] exp_v,
                                       logic signed [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{stall_velocity: StallVelocityRst, stall_current: StallCurrentRst,
                 jam_tick_limit: JamTickLimitRst, reverse_time_ms: ReverseTimeMsRst,
                 near_distance: NearDistanceRst, distance_jump: DistanceJumpRst,
                 hold_auto_loaded: HoldAutoLoadedRst,
                 hold_manual_loaded: HoldManualLoadedRst};
         tally         = 0;
         last_distance = '0;
         hold_left     = '0;
         stall_run     = 0;
         reverse_start = '0;
         intake_drive  = '0;
         roller_drive  = '0;
         drive_results.delete();
      end else begin
         // Register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_STALL_VELOCITY:     cfg.stall_velocity     = csr_data[9:0];
               CSR_STALL_CURRENT:      cfg.stall_current      = csr_data[11:0];
               CSR_JAM_TICK_LIMIT:     cfg.jam_tick_limit     = csr_data[7:0];
               CSR_REVERSE_TIME_MS:    cfg.reverse_time_ms    = csr_data;
               CSR_NEAR_DISTANCE:      cfg.near_distance      = csr_data[13:0];
               CSR_DISTANCE_JUMP:      cfg.distance_jump      = csr_data[13:0];
               CSR_HOLD_AUTO_LOADED:   cfg.hold_auto_loaded   = csr_data[5:0];
               CSR_HOLD_MANUAL_LOADED: cfg.hold_manual_loaded = csr_data[5:0];
               default: ;
            endcase
         end
         // Predict on every accepted tick
         if (req_tvalid && req_tready) begin
            tick_in.mode            = mode_type'(req_tuser);
            tick_in.motor_velocity  = req_tdata[10:0];
            tick_in.motor_current   = req_tdata[22:11];
            tick_in.sensed_distance = req_tdata[36:23];
            tick_in.time_ms         = req_tdata[68:37];
            drive_results.push_back(intake_tick(tick_in));
         end
         // Compare each result beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (drive_results.size() == 0) begin
               $error("result beat with no tick outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               want             = drive_results.pop_front();
               got.intake_drive = rsp_tdata[14:0];
               got.roller_drive = rsp_tdata[27:15];
               got.item_count   = rsp_tdata[31:28];
               got.reversing    = rsp_tdata[32];
               check_field("intake_drive", 16'($signed(want.intake_drive)),
                           16'($signed(got.intake_drive)));
               check_field("roller_drive", 16'(want.roller_drive), 16'(got.roller_drive));
               check_field("item_count", 16'(want.item_count), 16'(got.item_count));
               check_field("reversing", 16'(want.reversing), 16'(got.reversing));
            end
         end
      end
      outstanding <= drive_results.size();
      mismatches  <= errors;
   end

endmodule

### sim/tb_intake_jam_and_item_counter.sv
// Testbench top for the intake jam guard and item counter: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_intake_jam_and_item_counter;
   import ijic_pkg::*;

   localparam int IdleLimit = 2000;

   localparam cfg_type KnobsRst = '{
      stall_velocity: StallVelocityRst, stall_current: StallCurrentRst,
      jam_tick_limit: JamTickLimitRst, reverse_time_ms: ReverseTimeMsRst,
      near_distance: NearDistanceRst, distance_jump: DistanceJumpRst,
      hold_auto_loaded: HoldAutoLoadedRst, hold_manual_loaded: HoldManualLoadedRst};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;   // [1:0] mode
   logic [71:0] req_tdata = '0;   // [10:0] motor_velocity, [22:11] motor_current,
                                  // [36:23] sensed_distance, [68:37] time_ms, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [14:0] intake_drive, [27:15] roller_drive,
                                  // [31:28] item_count, [32] reversing, rest zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int          outstanding;
   int          mismatches;

   // Stimulus state
   cfg_type     knobs = KnobsRst;
   logic [31:0] now_ms = '0;
   int          sent = 0;
   int          gap_pct = 25;
   int          stall_pct = 25;
   bit          calm = 1'b0;
   int          rsp_hold = 0;
   int          idle_cycles = 0;

   always #2 clock = ~clock;

   intake_jam_and_item_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ijic_drive_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Result side: stall in bursts of random length
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_hold = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when no beat moves for too long
   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // Send one tick beat, then maybe leave a gap
   task automatic drive_tick(mode_type mode, int vel, int cur, int distance, logic [31:0] tms);
      logic [10:0] vel_bits;
      logic [11:0] cur_bits;
      logic [13:0] dist_bits;
      vel_bits  = vel[10:0];
      cur_bits  = cur[11:0];
      dist_bits = distance[13:0];
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, tms, dist_bits, cur_bits, vel_bits};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Hold the sender until every predicted result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(cfg_type c);
      put_reg(CSR_STALL_VELOCITY, 16'(c.stall_velocity));
      put_reg(CSR_STALL_CURRENT, 16'(c.stall_current));
      put_reg(CSR_JAM_TICK_LIMIT, 16'(c.jam_tick_limit));
      put_reg(CSR_REVERSE_TIME_MS, c.reverse_time_ms);
      put_reg(CSR_NEAR_DISTANCE, 16'(c.near_distance));
      put_reg(CSR_DISTANCE_JUMP, 16'(c.distance_jump));
      put_reg(CSR_HOLD_AUTO_LOADED, 16'(c.hold_auto_loaded));
      put_reg(CSR_HOLD_MANUAL_LOADED, 16'(c.hold_manual_loaded));
      csr_valid <= 1'b0;
      knobs = c;
   endtask

   function automatic cfg_type random_knobs();
      cfg_type c;
      c.stall_velocity     = 10'($urandom_range(0, 1023));
      c.stall_current      = 12'($urandom_range(0, 4095));
      c.jam_tick_limit     = 8'($urandom_range(0, 20));
      c.reverse_time_ms    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 3000));
      c.near_distance      = 14'($urandom_range(0, 400));
      c.distance_jump      = 14'($urandom_range(0, 600));
      c.hold_auto_loaded   = 6'($urandom_range(0, 63));
      c.hold_manual_loaded = 6'($urandom_range(0, 63));
      return c;
   endfunction

   function automatic logic [31:0] next_ms();
      now_ms = now_ms + $urandom_range(0, 25);
      return now_ms;
   endfunction

   // Velocity below the stall threshold when asked, else anywhere in range
   function automatic int pick_vel(bit stalled);
      int v;
      if (stalled) begin
         v = (knobs.stall_velocity == 0) ? 0 : $urandom_range(0, int'(knobs.stall_velocity) - 1);
         if ($urandom_range(0, 1) != 0) v = -v;
      end else begin
         v = int'($urandom_range(0, 2046)) - 1023;
      end
      return v;
   endfunction

   function automatic int pick_cur(bit stalled);
      if (stalled && knobs.stall_current != 12'hFFF)
         return $urandom_range(int'(knobs.stall_current) + 1, 4095);
      return $urandom_range(0, 4095);
   endfunction

   // Distance far enough that the next near reading counts an item in
   function automatic int pick_far();
      int lo;
      lo = int'(knobs.near_distance) + int'(knobs.distance_jump) + 1;
      if (lo > 16383) lo = int'(knobs.near_distance);
      return $urandom_range(lo, 16383);
   endfunction

   function automatic int pick_near();
      if (knobs.near_distance == 0) return 0;
      return $urandom_range(0, int'(knobs.near_distance) - 1);
   endfunction

   // Random traffic: mostly well-formed stall runs and item passes, some noise
   task automatic play(int count);
      int goal, kind, len, far_n, near_n, i, base, hi, top;
      mode_type mode;
      goal = sent + count;
      while (sent < goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 22) begin
            // stall run long enough to latch the reverse window
            len = int'(knobs.jam_tick_limit) + $urandom_range(1, 6);
            if ($urandom_range(0, 11) == 0) len = 262;
            for (i = 0; i < len; i++)
               drive_tick(MODE_AUTO, pick_vel(1), pick_cur(1), pick_far(), next_ms());
         end else if (kind < 55) begin
            // item arriving: far, near, then far while the roller hold runs down
            mode   = ($urandom_range(0, 1) != 0) ? MODE_MANUAL : MODE_AUTO;
            far_n  = $urandom_range(1, 2);
            near_n = $urandom_range(1, 3);
            len    = far_n + near_n + $urandom_range(0, 30);
            for (i = 0; i < len; i++)
               drive_tick(mode, pick_vel(0), pick_cur(0),
                          (i >= far_n && i < far_n + near_n) ? pick_near() : pick_far(),
                          next_ms());
         end else if (kind < 75) begin
            // item leaving: low reading, then a sharp rise
            top = 16383 - int'(knobs.distance_jump) - 1;
            if (top < 0) top = 0;
            base = $urandom_range(0, top);
            hi   = base + int'(knobs.distance_jump) + 1 + $urandom_range(0, 200);
            if (hi > 16383) hi = 16383;
            drive_tick(MODE_OUTTAKE, pick_vel(0), pick_cur(0), base, next_ms());
            drive_tick(MODE_OUTTAKE, pick_vel(0), pick_cur(0), hi, next_ms());
         end else if (kind < 78) begin
            drive_tick(MODE_CLEAR, pick_vel(0), pick_cur(0), $urandom_range(0, 16383),
                       next_ms());
         end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 3) == 0) now_ms = $urandom();
               drive_tick(mode_type'($urandom_range(0, 3)), pick_vel(0),
                          $urandom_range(0, 4095), $urandom_range(0, 16383), next_ms());
            end
         end
      end
   endtask

   // Directed ticks at reset settings
   task automatic directed_ticks();
      int i;
      // window after reset, hold when empty
      drive_tick(MODE_AUTO, 0, 0, 0, 32'd0);
      drive_tick(MODE_MANUAL, 1023, 4095, 16383, 32'd1);
      // count in from manual, hold for an empty magazine
      drive_tick(MODE_MANUAL, -1023, 0, 0, 32'd2);
      // last tick still inside the window
      drive_tick(MODE_AUTO, -1023, 4095, 16383, 32'd1000);
      drive_tick(MODE_AUTO, 1023, 0, 0, 32'd1001);
      drive_tick(MODE_AUTO, 0, 0, 200, 32'd1002);
      // outtake counts down, then stops at zero
      drive_tick(MODE_OUTTAKE, 0, 0, 0, 32'd1003);
      drive_tick(MODE_OUTTAKE, 0, 0, 16383, 32'd1004);
      drive_tick(MODE_CLEAR, 0, 0, 5000, 32'd1005);
      drive_tick(MODE_OUTTAKE, 0, 0, 0, 32'd1006);
      drive_tick(MODE_OUTTAKE, 0, 0, 16383, 32'd1007);
      // stall run near the top of the time range: window end beyond 32 bits
      for (i = 0; i < 12; i++)
         drive_tick(MODE_AUTO, (i % 2 != 0) ? -5 : 5, 4095, 100, 32'hFFFF_FF00 + i);
      drive_tick(MODE_AUTO, 500, 0, 100, 32'hFFFF_FFFF);
      now_ms = 32'd5000;
   endtask

   initial begin
      int ph;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      directed_ticks();
      play(150);

      for (ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0:       set_config('0);
            1:       set_config('1);
            7:       set_config(KnobsRst);
            default: set_config(random_knobs());
         endcase
         gap_pct   = (ph == 3) ? 0 : 25;
         stall_pct = (ph == 3) ? 0 : 25;
         if (ph == 7) calm = 1'b1;
         play(170);
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
